FILE: sv/owik_pkg.sv
// Shared types and constants for the omni-wheel inverse kinematics pipeline.
package owik_pkg;

    localparam int NUM_WHEELS = 4;

    // configuration channel
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL0_ANGLE    = 4'd0,
        REG_WHEEL1_ANGLE    = 4'd1,
        REG_WHEEL2_ANGLE    = 4'd2,
        REG_WHEEL3_ANGLE    = 4'd3,
        REG_CENTER_DISTANCE = 4'd4,
        REG_RPM_SCALE       = 4'd5,
        REG_MAX_SPEED       = 4'd6,
        REG_ABSOLUTE_MODE   = 4'd7
    } t_reg_idx;

    // field widths
    localparam int ANGLE_W = 16;
    localparam int DIST_W  = 12;
    localparam int SCALE_W = 20;
    localparam int LIM_W   = 23;
    localparam int SPEED_W = 24;
    localparam int TURN_W  = 24;
    localparam int RPM_W   = 16;
    localparam int T_W     = 15;   // folded quarter-turn phase, 0..16384
    localparam int COS_W   = 15;   // cosine magnitude, 0..32767
    localparam int ROT_W   = 42;   // rotation term, Q20 << 5
    localparam int PROJ_W  = 40;   // speed * cos
    localparam int V_W     = 42;   // projection + rotation
    localparam int SPLIT_W = 21;   // low half of v for the partial products
    localparam int PROD_W  = 63;   // v * rpm_scale

    // reset values
    localparam logic [ANGLE_W-1:0] RST_WHEEL0_ANGLE    = 16'd8192;
    localparam logic [ANGLE_W-1:0] RST_WHEEL1_ANGLE    = 16'd24576;
    localparam logic [ANGLE_W-1:0] RST_WHEEL2_ANGLE    = 16'd40960;
    localparam logic [ANGLE_W-1:0] RST_WHEEL3_ANGLE    = 16'd57344;
    localparam logic [DIST_W-1:0]  RST_CENTER_DISTANCE = 12'd307;
    localparam logic [SCALE_W-1:0] RST_RPM_SCALE       = 20'd132019;
    localparam logic [LIM_W-1:0]   RST_MAX_SPEED       = 23'd3072;

    // cosine polynomial, Q15 in u^2
    localparam int COS_K0      = 30;
    localparam int COS_K1      = 684;
    localparam int COS_K2      = 8312;
    localparam int COS_K3      = 40426;
    localparam int COS_ONE     = 32768;
    localparam int COS_MAX     = 32767;
    localparam int QUARTER16   = 16384;
    localparam int W_SHIFT     = 13;
    localparam int POLY_SHIFT  = 15;
    localparam int ROT_SHIFT   = 5;
    localparam int RPM_SHIFT   = 33;

    localparam logic [RPM_W-1:0] RPM_POS_SAT = 16'h7FFF;
    localparam logic [RPM_W-1:0] RPM_NEG_SAT = 16'h8000;

    // register banks inside one wheel lane
    localparam int LANE_STAGES = 10;

    typedef struct packed {
        logic [NUM_WHEELS-1:0][ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]                  center_distance;
        logic [SCALE_W-1:0]                 rpm_scale;
        logic [LIM_W-1:0]                   max_speed;
        logic                               absolute_mode;
    } t_cfg;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic           neg;
    } t_fold;

    typedef struct packed {
        logic                    valid;
        logic [SPEED_W-1:0]      speed;
        logic [ROT_W-1:0]        rot;
        t_fold [NUM_WHEELS-1:0]  fold;
    } t_front;

endpackage

FILE: sv/owik_cfg_regs.sv
// Configuration register file for the kinematics block.
module owik_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [owik_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owik_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output owik_pkg::t_cfg                 o_cfg
);
    import owik_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle[0]        <= RST_WHEEL0_ANGLE;
            r_cfg.angle[1]        <= RST_WHEEL1_ANGLE;
            r_cfg.angle[2]        <= RST_WHEEL2_ANGLE;
            r_cfg.angle[3]        <= RST_WHEEL3_ANGLE;
            r_cfg.center_distance <= RST_CENTER_DISTANCE;
            r_cfg.rpm_scale       <= RST_RPM_SCALE;
            r_cfg.max_speed       <= RST_MAX_SPEED;
            r_cfg.absolute_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WHEEL0_ANGLE:    r_cfg.angle[0] <= i_cfg_data[ANGLE_W-1:0];
                REG_WHEEL1_ANGLE:    r_cfg.angle[1] <= i_cfg_data[ANGLE_W-1:0];
                REG_WHEEL2_ANGLE:    r_cfg.angle[2] <= i_cfg_data[ANGLE_W-1:0];
                REG_WHEEL3_ANGLE:    r_cfg.angle[3] <= i_cfg_data[ANGLE_W-1:0];
                REG_CENTER_DISTANCE: r_cfg.center_distance <= i_cfg_data[DIST_W-1:0];
                REG_RPM_SCALE:       r_cfg.rpm_scale <= i_cfg_data[SCALE_W-1:0];
                REG_MAX_SPEED:       r_cfg.max_speed <= i_cfg_data[LIM_W-1:0];
                REG_ABSOLUTE_MODE:   r_cfg.absolute_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: sv/owik_front.sv
// Front stage: speed clamp, heading compensation, per-wheel phase fold, rotation term.
module owik_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic signed [owik_pkg::SPEED_W-1:0] i_target_speed,
    input  logic [owik_pkg::ANGLE_W-1:0]       i_target_heading,
    input  logic signed [owik_pkg::TURN_W-1:0]  i_target_turn_rate,
    input  logic [owik_pkg::ANGLE_W-1:0]       i_measured_yaw,
    input  owik_pkg::t_cfg                     i_cfg,
    output owik_pkg::t_front                   o_front
);
    import owik_pkg::*;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic signed [SPEED_W:0]   spd_ext;
    logic signed [SPEED_W:0]   lim_pos;
    logic signed [SPEED_W:0]   lim_neg;
    logic [SPEED_W-1:0]        spd_clamp;
    logic [31:0]               head32;
    logic [31:0]               yaw32;
    logic [ANGLE_BITS-1:0]     dir;
    logic [ANGLE_BITS-1:0]     yaw_off;
    logic [NUM_WHEELS-1:0][31:0]           ang32;
    logic [NUM_WHEELS-1:0][ANGLE_BITS-1:0] phase;
    logic [NUM_WHEELS-1:0][ANGLE_BITS+15:0] phase_ext;
    logic [NUM_WHEELS-1:0][15:0]           p16;
    logic signed [TURN_W+DIST_W:0]         rot_prod;
    t_fold [NUM_WHEELS-1:0]                fold;

    logic                      r_valid;
    logic [SPEED_W-1:0]        r_speed;
    logic [ROT_W-1:0]          r_rot;
    t_fold [NUM_WHEELS-1:0]    r_fold;

    always_comb begin
        spd_ext = {i_target_speed[SPEED_W-1], i_target_speed};
        lim_pos = $signed({2'b00, i_cfg.max_speed});
        lim_neg = -lim_pos;
        priority if (spd_ext > lim_pos) begin
            spd_clamp = lim_pos[SPEED_W-1:0];
        end else if (spd_ext < lim_neg) begin
            spd_clamp = lim_neg[SPEED_W-1:0];
        end else begin
            spd_clamp = spd_ext[SPEED_W-1:0];
        end

        head32  = 32'(i_target_heading);
        yaw32   = 32'(i_measured_yaw);
        yaw_off = yaw32[ANGLE_BITS-1:0] - QUARTER_TURN;
        dir     = i_cfg.absolute_mode ? head32[ANGLE_BITS-1:0] - yaw_off
                                      : head32[ANGLE_BITS-1:0];

        for (int i = 0; i < NUM_WHEELS; i++) begin
            ang32[i]     = 32'(i_cfg.angle[i]);
            phase[i]     = ang32[i][ANGLE_BITS-1:0] - dir;
            // top 16 bits of the phase, zero-filled when the angle is narrower
            phase_ext[i] = {phase[i], 16'h0000};
            p16[i]       = phase_ext[i][ANGLE_BITS+15:ANGLE_BITS];
            fold[i].neg  = p16[i][15] ^ p16[i][14];
            fold[i].t    = p16[i][14] ? T_W'(QUARTER16) - {1'b0, p16[i][13:0]}
                                      : {1'b0, p16[i][13:0]};
        end

        rot_prod = i_target_turn_rate * $signed({1'b0, i_cfg.center_distance});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_speed <= spd_clamp;
        r_rot   <= {rot_prod, ROT_SHIFT'(0)};
        r_fold  <= fold;
    end

    assign o_front.valid = r_valid;
    assign o_front.speed = r_speed;
    assign o_front.rot   = r_rot;
    assign o_front.fold  = r_fold;

endmodule

FILE: sv/owik_lane.sv
// One wheel lane: cosine polynomial, projection, rpm scaling and saturation.
module owik_lane (
    input  logic                          i_clk,
    input  owik_pkg::t_fold               i_fold,
    input  logic [owik_pkg::SPEED_W-1:0]  i_speed,
    input  logic [owik_pkg::ROT_W-1:0]    i_rot,
    input  logic [owik_pkg::SCALE_W-1:0]  i_rpm_scale,
    output logic [owik_pkg::RPM_W-1:0]    o_rpm
);
    import owik_pkg::*;

    // carried alongside the cosine stages
    logic [SPEED_W-1:0] r2_spd, r3_spd, r4_spd, r5_spd, r6_spd;
    logic [ROT_W-1:0]   r2_rot, r3_rot, r4_rot, r5_rot, r6_rot, r7_rot;
    logic               r2_neg, r3_neg, r4_neg, r5_neg, r6_neg;
    logic [15:0]        r2_w, r3_w, r4_w, r5_w;

    logic [9:0]              r3_h;
    logic [13:0]             r4_h;
    logic [15:0]             r5_h;
    logic [COS_W-1:0]        r6_c;
    logic signed [PROJ_W-1:0] r7_p;
    logic signed [V_W-1:0]   r8_v;
    logic [SPLIT_W+SCALE_W-1:0] r9_lo;
    logic signed [V_W-1:0]   r9_hi;
    logic signed [PROD_W-1:0] r10_prod;
    logic [RPM_W-1:0]        r11_rpm;

    logic [29:0]              sq;
    logic [20:0]              m1;
    logic [25:0]              m2;
    logic [29:0]              m3;
    logic [31:0]              m4;
    logic signed [17:0]       c18;
    logic [COS_W-1:0]         n6_c;
    logic signed [15:0]       cs;
    logic signed [PROJ_W-1:0] n7_p;
    logic signed [V_W-1:0]    n8_v;
    logic [SPLIT_W+SCALE_W-1:0] n9_lo;
    logic signed [V_W-1:0]    n9_hi;
    logic signed [PROD_W-1:0] n10_prod;
    logic                     pneg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-RPM_SHIFT-1:0] sh;
    logic [RPM_W-1:0]         n11_rpm;

    always_comb begin
        sq = 30'(i_fold.t) * 30'(i_fold.t);
        m1 = 21'(COS_K0) * 21'(r2_w);
        m2 = 26'(r3_h) * 26'(r3_w);
        m3 = 30'(r4_h) * 30'(r4_w);
        m4 = 32'(r5_h) * 32'(r5_w);

        c18 = $signed(18'(COS_ONE)) - $signed({1'b0, m4[31:POLY_SHIFT]});
        if (c18[17]) begin
            n6_c = '0;
        end else if (c18[15]) begin
            n6_c = COS_W'(COS_MAX);
        end else begin
            n6_c = c18[COS_W-1:0];
        end

        cs   = r6_neg ? -$signed({1'b0, r6_c}) : $signed({1'b0, r6_c});
        n7_p = $signed(r6_spd) * cs;

        n8_v = {{(V_W-PROJ_W){r7_p[PROJ_W-1]}}, r7_p} + $signed(r7_rot);

        // v split into an unsigned low part and a signed high part
        n9_lo = (SPLIT_W+SCALE_W)'(r8_v[SPLIT_W-1:0]) * (SPLIT_W+SCALE_W)'(i_rpm_scale);
        n9_hi = $signed(r8_v[V_W-1:SPLIT_W]) * $signed({1'b0, i_rpm_scale});

        n10_prod = $signed({r9_hi, SPLIT_W'(0)})
                 + $signed({(PROD_W-SPLIT_W-SCALE_W)'(0), r9_lo});

        // truncate the magnitude, then saturate
        pneg = r10_prod[PROD_W-1];
        mag  = pneg ? PROD_W'(-r10_prod) : PROD_W'(r10_prod);
        sh   = mag[PROD_W-1:RPM_SHIFT];
        if (pneg) begin
            n11_rpm = (sh > (PROD_W-RPM_SHIFT)'(COS_ONE)) ? RPM_NEG_SAT
                                                         : ~sh[RPM_W-1:0] + 1'b1;
        end else begin
            n11_rpm = (sh > (PROD_W-RPM_SHIFT)'(COS_MAX)) ? RPM_POS_SAT : sh[RPM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_w   <= sq[28:W_SHIFT];
        r2_neg <= i_fold.neg;
        r2_spd <= i_speed;
        r2_rot <= i_rot;

        r3_h   <= 10'(COS_K1) - 10'(m1[20:POLY_SHIFT]);
        r3_w   <= r2_w;
        r3_neg <= r2_neg;
        r3_spd <= r2_spd;
        r3_rot <= r2_rot;

        r4_h   <= 14'(COS_K2) - 14'(m2[25:POLY_SHIFT]);
        r4_w   <= r3_w;
        r4_neg <= r3_neg;
        r4_spd <= r3_spd;
        r4_rot <= r3_rot;

        r5_h   <= 16'(COS_K3) - 16'(m3[29:POLY_SHIFT]);
        r5_w   <= r4_w;
        r5_neg <= r4_neg;
        r5_spd <= r4_spd;
        r5_rot <= r4_rot;

        r6_c   <= n6_c;
        r6_neg <= r5_neg;
        r6_spd <= r5_spd;
        r6_rot <= r5_rot;

        r7_p   <= n7_p;
        r7_rot <= r6_rot;

        r8_v   <= n8_v;

        r9_lo  <= n9_lo;
        r9_hi  <= n9_hi;

        r10_prod <= n10_prod;

        r11_rpm  <= n11_rpm;
    end

    assign o_rpm = r11_rpm;

endmodule

FILE: sv/omni_wheel_inverse_kinematics.sv
// Four-wheel omni chassis inverse kinematics, top level.
//
// Command channel: drive the four command fields and raise start; a beat is
// taken at every clock edge with start high, busy is never raised, so one
// command may follow another in every cycle.
// Result channel: o_valid is high for exactly one cycle with the four wheel
// rpm targets of one command; results leave in command order.
// Throughput: one command per cycle, set by the fully pipelined wheel lanes
// (front stage, five cosine stages, projection, sum, split rpm product,
// product sum, saturation); each command passes these registers in that order.
// Configuration: write beats on i_cfg_valid/o_cfg_ready, always ready; write
// registers only while no command is in flight. Unknown indices are dropped.
// Reset (synchronous, active low) restores the default geometry and clears
// the in-flight valid bits; results already in the pipe are discarded.
// The receiver cannot stall; results must be taken when o_valid is high.
module omni_wheel_inverse_kinematics #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [owik_pkg::SPEED_W-1:0] i_target_speed,
    input  logic [owik_pkg::ANGLE_W-1:0]        i_target_heading,
    input  logic signed [owik_pkg::TURN_W-1:0]  i_target_turn_rate,
    input  logic [owik_pkg::ANGLE_W-1:0]        i_measured_yaw,
    output logic                                o_valid,
    output logic signed [owik_pkg::RPM_W-1:0]   o_wheel0_rpm,
    output logic signed [owik_pkg::RPM_W-1:0]   o_wheel1_rpm,
    output logic signed [owik_pkg::RPM_W-1:0]   o_wheel2_rpm,
    output logic signed [owik_pkg::RPM_W-1:0]   o_wheel3_rpm,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [owik_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [owik_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import owik_pkg::*;

    localparam int LATENCY = LANE_STAGES + 1;

    t_cfg                          cfg;
    t_front                        front;
    logic [NUM_WHEELS-1:0][RPM_W-1:0] rpm;
    logic [LANE_STAGES-1:0]        r_vld;

    assign busy = 1'b0;

    owik_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    owik_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (start && !busy),
        .i_target_speed     (i_target_speed),
        .i_target_heading   (i_target_heading),
        .i_target_turn_rate (i_target_turn_rate),
        .i_measured_yaw     (i_measured_yaw),
        .i_cfg              (cfg),
        .o_front            (front)
    );

    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        owik_lane u_lane (
            .i_clk       (i_clk),
            .i_fold      (front.fold[g]),
            .i_speed     (front.speed),
            .i_rot       (front.rot),
            .i_rpm_scale (cfg.rpm_scale),
            .o_rpm       (rpm[g])
        );
    end

    // valid bits keep step with the lane register banks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_STAGES-2:0], front.valid};
        end
    end

    assign o_valid      = r_vld[LANE_STAGES-1];
    assign o_wheel0_rpm = rpm[0];
    assign o_wheel1_rpm = rpm[1];
    assign o_wheel2_rpm = rpm[2];
    assign o_wheel3_rpm = rpm[3];

`ifndef SYNTHESIS
    a_result_has_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result beat without a command beat %0d cycles earlier", LATENCY);

    a_fold_in_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front.valid |-> (front.fold[0].t <= T_W'(QUARTER16) &&
                         front.fold[1].t <= T_W'(QUARTER16) &&
                         front.fold[2].t <= T_W'(QUARTER16) &&
                         front.fold[3].t <= T_W'(QUARTER16)))
        else $error("folded phase beyond a quarter turn");

    a_speed_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front.valid |->
            ($signed({front.speed[SPEED_W-1], front.speed})
                 <= $signed({2'b00, $past(cfg.max_speed)}) &&
             $signed({front.speed[SPEED_W-1], front.speed})
                 >= -$signed({2'b00, $past(cfg.max_speed)})))
        else $error("clamped speed outside the speed limit");
`endif

endmodule

FILE: verif/tb_omni_wheel_inverse_kinematics.sv
// Self-checking testbench for the omni-wheel inverse kinematics pipeline.
`timescale 1ns / 1ps

module tb_omni_wheel_inverse_kinematics;
    import owik_pkg::*;

    localparam int LATENCY     = 11;
    localparam int PER_GEOMETRY = 85;
    localparam int GEOMETRIES  = 6;

    localparam logic signed [SPEED_W-1:0] SPEED_TOP = 24'sh7FFFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_BOT = 24'sh800000;
    localparam logic [RPM_W-1:0] RPM_HI = 16'h7FFF;
    localparam logic [RPM_W-1:0] RPM_LO = 16'h8000;

    // cosine polynomial in u^2, Q15
    localparam longint POLY_A = 30;
    localparam longint POLY_B = 684;
    localparam longint POLY_C = 8312;
    localparam longint POLY_D = 40426;

    typedef logic [NUM_WHEELS-1:0][RPM_W-1:0] t_rpm_set;

    typedef struct {
        logic signed [SPEED_W-1:0] speed;
        logic [ANGLE_W-1:0]        heading;
        logic signed [TURN_W-1:0]  turn;
        logic [ANGLE_W-1:0]        yaw;
    } t_command;

    typedef struct {
        t_command cmd;
        bit       typed;
        t_rpm_set rpm;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [SPEED_W-1:0]   i_target_speed = '0;
    logic [ANGLE_W-1:0]          i_target_heading = '0;
    logic signed [TURN_W-1:0]    i_target_turn_rate = '0;
    logic [ANGLE_W-1:0]          i_measured_yaw = '0;
    logic                        o_valid;
    logic signed [RPM_W-1:0]     o_wheel0_rpm;
    logic signed [RPM_W-1:0]     o_wheel1_rpm;
    logic signed [RPM_W-1:0]     o_wheel2_rpm;
    logic signed [RPM_W-1:0]     o_wheel3_rpm;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    t_cfg     geom;
    t_rpm_set rpm_due_q[$];
    int       mismatch_count = 0;

    // directed commands, among them headings chosen to land on wheel mounts and quadrant edges
    t_row directed_rows[] = '{
        '{'{24'sd0, 16'd0, 24'sd0, 16'd0}, 1'b1, '0},
        '{'{24'sd0, 16'd0, SPEED_TOP, 16'd0}, 1'b1, {4{RPM_HI}}},
        '{'{24'sd0, 16'hFFFF, SPEED_BOT, 16'hFFFF}, 1'b1, {4{RPM_LO}}},
        '{'{SPEED_BOT, 16'h1234, SPEED_TOP, 16'd0}, 1'b1, {4{RPM_HI}}},
        '{'{SPEED_TOP, 16'hFFFF, SPEED_BOT, 16'h8000}, 1'b1, {4{RPM_LO}}},
        '{'{SPEED_TOP, 16'd0, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{SPEED_BOT, 16'd0, 24'sd0, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd3072, 16'd8192, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd3072, 16'd16384, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd3072, 16'd24576, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd3072, 16'd32768, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd3072, 16'd40960, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd3072, 16'd49152, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd3072, 16'd57344, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd3071, 16'hFFFF, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{-24'sd3073, 16'd1, 24'sd0, 16'd0}, 1'b0, '0},
        '{'{24'sd1024, 16'd0, 24'sd1024, 16'd0}, 1'b0, '0},
        '{'{-24'sd2048, 16'd12345, -24'sd512, 16'd54321}, 1'b0, '0},
        '{'{24'sd1, 16'd100, 24'sd1, 16'd0}, 1'b0, '0},
        '{'{-24'sd1, 16'd200, -24'sd1, 16'd0}, 1'b0, '0},
        '{'{24'sd0, 16'd0, 24'sd2000, 16'd0}, 1'b0, '0},
        '{'{24'sd0, 16'd0, -24'sd2000, 16'd0}, 1'b0, '0}
    };

    omni_wheel_inverse_kinematics i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_target_speed     (i_target_speed),
        .i_target_heading   (i_target_heading),
        .i_target_turn_rate (i_target_turn_rate),
        .i_measured_yaw     (i_measured_yaw),
        .o_valid            (o_valid),
        .o_wheel0_rpm       (o_wheel0_rpm),
        .o_wheel1_rpm       (o_wheel1_rpm),
        .o_wheel2_rpm       (o_wheel2_rpm),
        .o_wheel3_rpm       (o_wheel3_rpm),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // t in 0..16384 of a quarter turn, result 0..32767
    function automatic longint quarter_cos(longint t);
        longint w, h, c;
        w = (t * t) >> 13;
        h = POLY_A;
        h = POLY_B - ((h * w) >> 15);
        h = POLY_C - ((h * w) >> 15);
        h = POLY_D - ((h * w) >> 15);
        c = 32768 - ((h * w) >> 15);
        if (c < 0) c = 0;
        if (c > 32767) c = 32767;
        return c;
    endfunction

    function automatic longint signed_cos(logic [ANGLE_W-1:0] p);
        longint r;
        r = p[13:0];
        case (p[15:14])
            2'd0: return quarter_cos(r);
            2'd1: return -quarter_cos(16384 - r);
            2'd2: return -quarter_cos(r);
            default: return quarter_cos(16384 - r);
        endcase
    endfunction

    function automatic t_rpm_set predict_wheel_rpm(t_command c);
        t_rpm_set res;
        longint spd, lim, rot, v, prod, mag;
        logic [ANGLE_W-1:0] hdg, phase;
        spd = c.speed;
        lim = longint'(geom.max_speed);
        if (spd > lim) spd = lim;
        if (spd < -lim) spd = -lim;
        hdg = c.heading;
        if (geom.absolute_mode)
            hdg = c.heading - (c.yaw - 16'd16384);
        rot = longint'(c.turn) * longint'(geom.center_distance) * 32;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            phase = geom.angle[i] - hdg;
            v = spd * signed_cos(phase) + rot;
            prod = v * longint'(geom.rpm_scale);
            mag = (prod < 0) ? -prod : prod;
            mag = mag >> 33;
            if (prod < 0)
                res[i] = (mag > 32768) ? RPM_LO : RPM_W'(-mag);
            else
                res[i] = (mag > 32767) ? RPM_HI : RPM_W'(mag);
        end
        return res;
    endfunction

    function automatic t_command random_command();
        t_command c;
        int span;
        c.heading = ANGLE_W'($urandom);
        c.yaw = ANGLE_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            c.speed = SPEED_W'($urandom);
            c.turn = TURN_W'($urandom);
        end else begin
            // mostly near the clamp so that the cosine term shows
            span = (geom.max_speed > 23'd8387583) ? 8388607 : int'(geom.max_speed) + 1024;
            c.speed = SPEED_W'($urandom_range(0, 2 * span) - span);
            c.turn = TURN_W'($urandom_range(0, 16384) - 8192);
        end
        return c;
    endfunction

    function automatic t_cfg random_geometry();
        t_cfg g;
        for (int i = 0; i < NUM_WHEELS; i++)
            g.angle[i] = ANGLE_W'($urandom);
        g.center_distance = DIST_W'($urandom_range(0, 4095));
        g.rpm_scale = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                                  : SCALE_W'($urandom_range(0, 300000));
        g.max_speed = ($urandom_range(0, 3) == 0) ? LIM_W'($urandom)
                                                  : LIM_W'($urandom_range(0, 16384));
        g.absolute_mode = 1'($urandom_range(0, 1));
        return g;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WHEEL0_ANGLE:    geom.angle[0] = data[ANGLE_W-1:0];
            REG_WHEEL1_ANGLE:    geom.angle[1] = data[ANGLE_W-1:0];
            REG_WHEEL2_ANGLE:    geom.angle[2] = data[ANGLE_W-1:0];
            REG_WHEEL3_ANGLE:    geom.angle[3] = data[ANGLE_W-1:0];
            REG_CENTER_DISTANCE: geom.center_distance = data[DIST_W-1:0];
            REG_RPM_SCALE:       geom.rpm_scale = data[SCALE_W-1:0];
            REG_MAX_SPEED:       geom.max_speed = data[LIM_W-1:0];
            REG_ABSOLUTE_MODE:   geom.absolute_mode = data[0];
            default: ;
        endcase
    endtask

    // junk_high fills the bits above each register's width with random data
    task automatic program_geometry(input t_cfg g, input bit junk_high);
        logic [CFG_DATA_W-1:0] pad;
        pad = junk_high ? CFG_DATA_W'($urandom) : '0;
        i_cfg_valid <= 1'b1;
        for (int w = 0; w < NUM_WHEELS; w++)
            write_reg(CFG_IDX_W'(REG_WHEEL0_ANGLE) + CFG_IDX_W'(w),
                      {pad[CFG_DATA_W-1:ANGLE_W], g.angle[w]});
        write_reg(REG_CENTER_DISTANCE, {pad[CFG_DATA_W-1:DIST_W], g.center_distance});
        write_reg(REG_RPM_SCALE, {pad[CFG_DATA_W-1:SCALE_W], g.rpm_scale});
        write_reg(REG_MAX_SPEED, {pad[CFG_DATA_W-1:LIM_W], g.max_speed});
        write_reg(REG_ABSOLUTE_MODE, {pad[CFG_DATA_W-1:1], g.absolute_mode});
        // unmapped index, must leave the geometry alone
        write_reg(CFG_IDX_W'(REG_ABSOLUTE_MODE) + CFG_IDX_W'($urandom_range(1, 8)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic issue(input t_command c, input bit typed, input t_rpm_set typed_rpm);
        start              <= 1'b1;
        i_target_speed     <= c.speed;
        i_target_heading   <= c.heading;
        i_target_turn_rate <= c.turn;
        i_measured_yaw     <= c.yaw;
        do @(posedge i_clk); while (busy);
        rpm_due_q.push_back(typed ? typed_rpm : predict_wheel_rpm(c));
    endtask

    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (rpm_due_q.size() != 0);
    endtask

    task automatic send_random(input int count);
        int burst_left;
        burst_left = 0;
        repeat (count) begin
            if (burst_left == 0) begin
                idle($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 10);
            end
            issue(random_command(), 1'b0, '0);
            burst_left--;
            if ($urandom_range(0, 99) == 0) begin
                drain();
                burst_left = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin : check_beat
        t_rpm_set due, got;
        if (i_rst_n && o_valid) begin
            got = {o_wheel3_rpm, o_wheel2_rpm, o_wheel1_rpm, o_wheel0_rpm};
            if (rpm_due_q.size() == 0) begin
                $display("%0t unexpected beat: rpm %0d %0d %0d %0d", $time,
                         $signed(got[0]), $signed(got[1]), $signed(got[2]),
                         $signed(got[3]));
                mismatch_count++;
            end else begin
                due = rpm_due_q.pop_front();
                for (int i = 0; i < NUM_WHEELS; i++)
                    if (got[i] !== due[i]) begin
                        $display("%0t wheel%0d_rpm expected %0d got %0d", $time, i,
                                 $signed(due[i]), $signed(got[i]));
                        mismatch_count++;
                    end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_cfg g;
        geom.angle[0] = 16'd8192;
        geom.angle[1] = 16'd24576;
        geom.angle[2] = 16'd40960;
        geom.angle[3] = 16'd57344;
        geom.center_distance = 12'd307;
        geom.rpm_scale = 20'd132019;
        geom.max_speed = 23'd3072;
        geom.absolute_mode = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            issue(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].rpm);
            if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 3));
        end
        send_random(PER_GEOMETRY);

        for (int p = 0; p < GEOMETRIES - 1; p++) begin
            drain();
            g = random_geometry();
            case (p)
                0: begin
                    g.angle = {16'd16384, 16'd32768, 16'hFFFF, 16'd0};
                    g.center_distance = 12'hFFF;
                    g.rpm_scale = 20'hFFFFF;
                    g.max_speed = 23'h7FFFFF;
                    g.absolute_mode = 1'b1;
                end
                1: g = '0;
                2: begin
                    // zero speed clamp, rotation only
                    g.max_speed = '0;
                    g.center_distance = 12'hFFF;
                    g.rpm_scale = 20'd2000;
                end
                default: ;
            endcase
            program_geometry(g, (p == 0) || ($urandom_range(0, 1) == 1));
            send_random(PER_GEOMETRY);
        end

        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0 && rpm_due_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
